>>> rtl/cascaded_complex_biquad_peak_filter_defines.svh
// assertion macros for the cascaded complex biquad peak filter
// used by the top level; expects signals clk and rst in scope
`ifndef CASCADED_COMPLEX_BIQUAD_PEAK_FILTER_DEFINES_SVH
`define CASCADED_COMPLEX_BIQUAD_PEAK_FILTER_DEFINES_SVH

// property that holds at every edge outside reset
`define CCBPF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// property whose consequence is checked in the cycle after the trigger
`define CCBPF_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

>>> rtl/ccbpf_pkg.sv
// shared types, constants and arithmetic helpers of the biquad peak filter
// no dependencies; used by the gain unit, the cell and the top level in rtl
`timescale 1ns / 1ps

package ccbpf_pkg;

  // default number of cells in the chain
  localparam int MAX_STAGES_DEF = 4;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int VAL_W    = 40;
  localparam int PART_W   = 21;
  localparam int PROD_W   = COEF_W + PART_W;
  localparam int ACC_W    = 56;
  localparam int LQ_W     = ACC_W - 20;
  localparam int GPROD_W  = SAMPLE_W + COEF_W;

  // one stage does five products, each split in a high and a low half
  localparam int N_TERMS   = 5;
  localparam int N_STEPS   = 2 * N_TERMS;
  localparam int STEP_W    = $clog2(N_STEPS);

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic                     RUN_RST   = 1'b0;
  localparam logic [2:0]               STAGE_RST = 3'd1;
  localparam logic signed [COEF_W-1:0] ONE_Q28   = 32'sh1000_0000;
  localparam logic signed [COEF_W-1:0] ZERO_Q28  = 32'sh0;

  // input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
  } out_item_t;

  // internal sample pair, Q.8 in 40 bits
  typedef struct packed {
    logic signed [VAL_W-1:0] lane_i;
    logic signed [VAL_W-1:0] lane_q;
  } lane_pair_t;

  // stage coefficients, all Q4.28
  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_t;

  // saturate a 48-bit value to 40 bits
  function automatic logic signed [VAL_W-1:0] sat40(input logic signed [47:0] v);
    logic same;
    begin
      same = (v[47:VAL_W-1] == {(48-VAL_W+1){1'b0}}) ||
             (v[47:VAL_W-1] == {(48-VAL_W+1){1'b1}});
      if (same) begin
        sat40 = v[VAL_W-1:0];
      end else if (v[47]) begin
        sat40 = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        sat40 = {1'b0, {(VAL_W-1){1'b1}}};
      end
    end
  endfunction

  // round half up from Q.8 to integer and saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] round_out(input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W:0]   s;
    logic signed [VAL_W-8:0] t;
    logic                    same;
    begin
      s = {y[VAL_W-1], y} + (VAL_W+1)'(128);
      t = s[VAL_W:8];
      same = (t[VAL_W-8:SAMPLE_W-1] == {(VAL_W-8-SAMPLE_W+2){1'b0}}) ||
             (t[VAL_W-8:SAMPLE_W-1] == {(VAL_W-8-SAMPLE_W+2){1'b1}});
      if (same) begin
        round_out = t[SAMPLE_W-1:0];
      end else if (t[VAL_W-8]) begin
        round_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        round_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

>>> rtl/ccbpf_gain.sv
// input gain unit: scales one I/Q sample by the Q4.28 gain, result in Q.8
// depends on ccbpf_pkg
`timescale 1ns / 1ps

module ccbpf_gain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [ccbpf_pkg::COEF_W-1:0] gain,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ccbpf_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccbpf_pkg::lane_pair_t               out_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND, S_HOLD} state_t;

  state_t                                      state;
  logic signed [ccbpf_pkg::SAMPLE_W-1:0]       x_i;
  logic signed [ccbpf_pkg::SAMPLE_W-1:0]       x_q;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        prod_i;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        prod_q;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        gain_ext;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        xi_ext;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        xq_ext;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        prod_i_next;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        prod_q_next;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        rnd_i;
  logic signed [ccbpf_pkg::GPROD_W-1:0]        rnd_q;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_HOLD);

  // sample times gain, exact in Q.28
  always_comb begin
    gain_ext    = {{(ccbpf_pkg::GPROD_W-ccbpf_pkg::COEF_W){gain[ccbpf_pkg::COEF_W-1]}}, gain};
    xi_ext      = {{(ccbpf_pkg::GPROD_W-ccbpf_pkg::SAMPLE_W){x_i[ccbpf_pkg::SAMPLE_W-1]}}, x_i};
    xq_ext      = {{(ccbpf_pkg::GPROD_W-ccbpf_pkg::SAMPLE_W){x_q[ccbpf_pkg::SAMPLE_W-1]}}, x_q};
    prod_i_next = xi_ext * gain_ext;
    prod_q_next = xq_ext * gain_ext;
    // round half up to Q.8; the result always fits in 40 bits
    rnd_i       = prod_i + ccbpf_pkg::GPROD_W'(524288);
    rnd_q       = prod_q + ccbpf_pkg::GPROD_W'(524288);
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_i   <= in_data.in_i;
            x_q   <= in_data.in_q;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_i <= prod_i_next;
          prod_q <= prod_q_next;
          state  <= S_RND;
        end
        S_RND: begin
          // arithmetic shift by 20, sign carried into the upper bits
          out_data.lane_i <= {{(ccbpf_pkg::VAL_W-ccbpf_pkg::GPROD_W+20)
                                {rnd_i[ccbpf_pkg::GPROD_W-1]}},
                              rnd_i[ccbpf_pkg::GPROD_W-1:20]};
          out_data.lane_q <= {{(ccbpf_pkg::VAL_W-ccbpf_pkg::GPROD_W+20)
                                {rnd_q[ccbpf_pkg::GPROD_W-1]}},
                              rnd_q[ccbpf_pkg::GPROD_W-1:20]};
          state           <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ccbpf_cell.sv
// one biquad cell: history of one stage for I and Q, one multiplier per lane
// depends on ccbpf_pkg
`timescale 1ns / 1ps

module ccbpf_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  ccbpf_pkg::coef_t      coef,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ccbpf_pkg::lane_pair_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccbpf_pkg::lane_pair_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_RND, S_SUM, S_HOLD} state_t;

  localparam logic [ccbpf_pkg::STEP_W-1:0] LAST_STEP = ccbpf_pkg::STEP_W'(ccbpf_pkg::N_STEPS - 1);

  state_t                                 state;
  logic [ccbpf_pkg::STEP_W-1:0]           step;

  // per lane history; lane 0 is I, lane 1 is Q
  logic signed [ccbpf_pkg::VAL_W-1:0]     x0 [2];
  logic signed [ccbpf_pkg::VAL_W-1:0]     x1 [2];
  logic signed [ccbpf_pkg::VAL_W-1:0]     x2 [2];
  logic signed [ccbpf_pkg::VAL_W-1:0]     y1 [2];
  logic signed [ccbpf_pkg::VAL_W-1:0]     y2 [2];

  // product pipeline and accumulators
  logic                                   prod_valid;
  logic                                   prod_lo;
  logic signed [ccbpf_pkg::PROD_W-1:0]    prod [2];
  logic signed [ccbpf_pkg::ACC_W-1:0]     sh [2];
  logic signed [ccbpf_pkg::ACC_W-1:0]     sl [2];
  logic signed [ccbpf_pkg::LQ_W-1:0]      lq [2];

  // combinational operands
  logic signed [ccbpf_pkg::COEF_W-1:0]    coef_sel;
  logic signed [ccbpf_pkg::PROD_W-1:0]    coef_ext;
  logic signed [ccbpf_pkg::VAL_W-1:0]     val_sel  [2];
  logic signed [ccbpf_pkg::PART_W-1:0]    part     [2];
  logic signed [ccbpf_pkg::PROD_W-1:0]    part_ext [2];
  logic signed [ccbpf_pkg::PROD_W-1:0]    prod_next [2];
  logic signed [ccbpf_pkg::ACC_W-1:0]     prod_acc  [2];
  logic signed [ccbpf_pkg::ACC_W-1:0]     sl_rnd    [2];
  logic signed [ccbpf_pkg::ACC_W-1:0]     total     [2];
  logic signed [ccbpf_pkg::VAL_W-1:0]     y_next    [2];

  assign in_ready        = (state == S_IDLE);
  assign out_valid       = (state == S_HOLD);
  assign out_data.lane_i = y1[0];
  assign out_data.lane_q = y1[1];

  // term select: step / 2 picks the tap, step bit 0 picks the half
  always_comb begin
    case (step[ccbpf_pkg::STEP_W-1:1])
      3'd0:    coef_sel = coef.a0;
      3'd1:    coef_sel = coef.a1;
      3'd2:    coef_sel = coef.a2;
      3'd3:    coef_sel = coef.b1;
      default: coef_sel = coef.b2;
    endcase
    coef_ext = {{(ccbpf_pkg::PROD_W-ccbpf_pkg::COEF_W){coef_sel[ccbpf_pkg::COEF_W-1]}}, coef_sel};
    for (int l = 0; l < 2; l++) begin
      case (step[ccbpf_pkg::STEP_W-1:1])
        3'd0:    val_sel[l] = x0[l];
        3'd1:    val_sel[l] = x1[l];
        3'd2:    val_sel[l] = x2[l];
        3'd3:    val_sel[l] = y1[l];
        default: val_sel[l] = y2[l];
      endcase
      // high half is signed, low half is 20 unsigned bits
      if (step[0]) begin
        part[l] = {1'b0, val_sel[l][19:0]};
      end else begin
        part[l] = {val_sel[l][ccbpf_pkg::VAL_W-1], val_sel[l][ccbpf_pkg::VAL_W-1:20]};
      end
      part_ext[l]  = {{(ccbpf_pkg::PROD_W-ccbpf_pkg::PART_W){part[l][ccbpf_pkg::PART_W-1]}},
                      part[l]};
      prod_next[l] = coef_ext * part_ext[l];
      prod_acc[l]  = {{(ccbpf_pkg::ACC_W-ccbpf_pkg::PROD_W){prod[l][ccbpf_pkg::PROD_W-1]}},
                      prod[l]};
      // round the low sum to the weight of the high sum
      sl_rnd[l]    = sl[l] + ccbpf_pkg::ACC_W'(134217728);
      total[l]     = sh[l] + {{(ccbpf_pkg::ACC_W-ccbpf_pkg::LQ_W){lq[l][ccbpf_pkg::LQ_W-1]}},
                              lq[l]};
      y_next[l]    = ccbpf_pkg::sat40(total[l][ccbpf_pkg::ACC_W-1:8]);
    end
  end

  // sequencer, multiply-accumulate and history
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prod_valid <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        x1[l] <= '0;
        x2[l] <= '0;
        y1[l] <= '0;
        y2[l] <= '0;
      end
    end else begin
      prod_valid <= (state == S_MUL);
      prod_lo    <= step[0];
      for (int l = 0; l < 2; l++) begin
        prod[l] <= prod_next[l];
        if (prod_valid) begin
          if (prod_lo) begin
            sl[l] <= sl[l] + prod_acc[l];
          end else begin
            sh[l] <= sh[l] + prod_acc[l];
          end
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x0[0] <= in_data.lane_i;
            x0[1] <= in_data.lane_q;
            for (int l = 0; l < 2; l++) begin
              sh[l] <= '0;
              sl[l] <= '0;
            end
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_RND;
        end
        S_RND: begin
          for (int l = 0; l < 2; l++) begin
            lq[l] <= sl_rnd[l][ccbpf_pkg::ACC_W-1:20];
          end
          state <= S_SUM;
        end
        S_SUM: begin
          for (int l = 0; l < 2; l++) begin
            x2[l] <= x1[l];
            x1[l] <= x0[l];
            y2[l] <= y1[l];
            y1[l] <= y_next[l];
          end
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // history flush after a register write
      if (clear) begin
        for (int l = 0; l < 2; l++) begin
          x1[l] <= '0;
          x2[l] <= '0;
          y1[l] <= '0;
          y2[l] <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/cascaded_complex_biquad_peak_filter.sv
// Cascaded complex biquad peak filter. Each I/Q sample is scaled by a Q4.28 gain
// and filtered by 1 to MAX_STAGES direct-form-I biquad cells in a chain, I and Q
// side by side in each cell, then rounded and saturated to 16 bits. Each cell
// runs multiply cycles (five taps, high and low half), then accumulate, round,
// history update and handoff, and an accept state; it takes a new sample only
// once it has handed off the last, the gain unit does the same, and cells work
// on successive samples at once. With run_enable low, samples go straight to
// the output register one per cycle while the output is not stalled, and the
// history is untouched. Writing any register other than run_enable clears all
// history. Registers sit at byte addresses 4 * index on the APB port.
// depends on ccbpf_pkg, ccbpf_gain, ccbpf_cell and the defines header
`timescale 1ns / 1ps
`include "cascaded_complex_biquad_peak_filter_defines.svh"

module cascaded_complex_biquad_peak_filter #(
  parameter int MAX_STAGES = ccbpf_pkg::MAX_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ccbpf_pkg::in_item_t            in_data,
  // sample output
  output logic                           out_valid,
  input  logic                           out_ready,
  output ccbpf_pkg::out_item_t           out_data,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ccbpf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ccbpf_pkg::DATA_W-1:0]   pwdata,
  output logic [ccbpf_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int         LW        = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam logic [3:0] MAX_COUNT = 4'(MAX_STAGES);

  typedef enum logic [2:0] {
    REG_RUN_ENABLE,
    REG_STAGE_COUNT,
    REG_INPUT_GAIN,
    REG_COEF_A0,
    REG_COEF_A1,
    REG_COEF_A2,
    REG_COEF_B1,
    REG_COEF_B2
  } reg_index_t;

  // configuration registers
  logic                                 run_enable;
  logic [2:0]                           stage_count;
  logic signed [ccbpf_pkg::COEF_W-1:0]  input_gain;
  ccbpf_pkg::coef_t                     coef;

  logic                                 wr_en;
  reg_index_t                           wr_index;
  logic                                 clear_hist;
  logic [3:0]                           count_eff;
  logic [LW-1:0]                        last_idx;

  // chain wiring
  logic                                 gain_in_valid;
  logic                                 gain_in_ready;
  logic                                 gain_out_valid;
  ccbpf_pkg::lane_pair_t                gain_out_data;
  logic                                 cell_in_valid  [MAX_STAGES];
  logic                                 cell_in_ready  [MAX_STAGES];
  ccbpf_pkg::lane_pair_t                cell_in_data   [MAX_STAGES];
  logic                                 cell_out_valid [MAX_STAGES];
  logic                                 cell_out_ready [MAX_STAGES];
  ccbpf_pkg::lane_pair_t                cell_out_data  [MAX_STAGES];
  logic                                 last_valid;
  ccbpf_pkg::lane_pair_t                last_data;

  // output register control
  logic                                 out_free;
  logic                                 src_valid;
  ccbpf_pkg::out_item_t                 src_data;

  // register write decode
  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite && pready;
  assign wr_index   = reg_index_t'(paddr[ccbpf_pkg::ADDR_W-1:2]);
  assign clear_hist = wr_en && (wr_index != REG_RUN_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable  <= ccbpf_pkg::RUN_RST;
      stage_count <= ccbpf_pkg::STAGE_RST;
      input_gain  <= ccbpf_pkg::ONE_Q28;
      coef.a0     <= ccbpf_pkg::ONE_Q28;
      coef.a1     <= ccbpf_pkg::ZERO_Q28;
      coef.a2     <= ccbpf_pkg::ZERO_Q28;
      coef.b1     <= ccbpf_pkg::ZERO_Q28;
      coef.b2     <= ccbpf_pkg::ZERO_Q28;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RUN_ENABLE:  run_enable  <= pwdata[0];
        REG_STAGE_COUNT: stage_count <= pwdata[2:0];
        REG_INPUT_GAIN:  input_gain  <= pwdata;
        REG_COEF_A0:     coef.a0     <= pwdata;
        REG_COEF_A1:     coef.a1     <= pwdata;
        REG_COEF_A2:     coef.a2     <= pwdata;
        REG_COEF_B1:     coef.b1     <= pwdata;
        REG_COEF_B2:     coef.b2     <= pwdata;
        default:         run_enable  <= run_enable;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (wr_index)
      REG_RUN_ENABLE:  prdata = {{(ccbpf_pkg::DATA_W-1){1'b0}}, run_enable};
      REG_STAGE_COUNT: prdata = {{(ccbpf_pkg::DATA_W-3){1'b0}}, stage_count};
      REG_INPUT_GAIN:  prdata = input_gain;
      REG_COEF_A0:     prdata = coef.a0;
      REG_COEF_A1:     prdata = coef.a1;
      REG_COEF_A2:     prdata = coef.a2;
      REG_COEF_B1:     prdata = coef.b1;
      REG_COEF_B2:     prdata = coef.b2;
      default:         prdata = '0;
    endcase
  end

  // stages in use: zero acts as one, above the chain length acts as the full chain
  always_comb begin
    count_eff = {1'b0, stage_count};
    if (count_eff == 4'd0) begin
      count_eff = 4'd1;
    end else if (count_eff > MAX_COUNT) begin
      count_eff = MAX_COUNT;
    end
    last_idx = LW'(count_eff - 4'd1);
  end

  // input side: gain unit when filtering, output register when bypassed
  assign out_free      = !out_valid || out_ready;
  assign gain_in_valid = in_valid && run_enable;
  assign in_ready      = run_enable ? gain_in_ready : out_free;

  ccbpf_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .gain      (input_gain),
    .in_valid  (gain_in_valid),
    .in_ready  (gain_in_ready),
    .in_data   (in_data),
    .out_valid (gain_out_valid),
    .out_ready (cell_in_ready[0]),
    .out_data  (gain_out_data)
  );

  // chain of biquad cells; the cell at last_idx feeds the output register
  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in_valid[k] = gain_out_valid;
      assign cell_in_data[k]  = gain_out_data;
    end else begin : g_link
      assign cell_in_valid[k] = cell_out_valid[k-1] && (LW'(k-1) < last_idx);
      assign cell_in_data[k]  = cell_out_data[k-1];
    end
    if (k < MAX_STAGES - 1) begin : g_mid
      assign cell_out_ready[k] = (last_idx == LW'(k)) ? out_free : cell_in_ready[k+1];
    end else begin : g_tail
      assign cell_out_ready[k] = out_free;
    end

    ccbpf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear_hist),
      .coef      (coef),
      .in_valid  (cell_in_valid[k]),
      .in_ready  (cell_in_ready[k]),
      .in_data   (cell_in_data[k]),
      .out_valid (cell_out_valid[k]),
      .out_ready (cell_out_ready[k]),
      .out_data  (cell_out_data[k])
    );
  end

  assign last_valid = cell_out_valid[last_idx];
  assign last_data  = cell_out_data[last_idx];

  // output source select
  always_comb begin
    if (run_enable) begin
      src_valid      = last_valid;
      src_data.out_i = ccbpf_pkg::round_out(last_data.lane_i);
      src_data.out_q = ccbpf_pkg::round_out(last_data.lane_q);
    end else begin
      src_valid      = in_valid;
      src_data.out_i = in_data.in_i;
      src_data.out_q = in_data.in_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= src_valid;
      if (src_valid) begin
        out_data <= src_data;
      end
    end
  end

  // checks
  `CCBPF_ASSERT_NEXT(a_bypass_copy, in_valid && in_ready && !run_enable, out_valid && out_data.out_i == $past(in_data.in_i) && out_data.out_q == $past(in_data.in_q), "bypass transfer not copied to output")
  `CCBPF_ASSERT_NEXT(a_last_hold, run_enable && last_valid && !out_free && !wr_en, last_valid, "last cell dropped a result while output stalled")
  `CCBPF_ASSERT_ALWAYS(a_last_range, last_idx <= LW'(MAX_STAGES - 1), "last stage index beyond chain")

endmodule
